// File: src/ibs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibs_pkg
// Shared constants and types for the indexed block search core.
// ----------------------------------------------------------------------------
package ibs_pkg;

    localparam int CAPACITY         = 64;
    localparam int VALUE_W          = 32;
    localparam int BSIZE_W          = 7;
    localparam int BLOCK_SIZE_RESET = 5;
    localparam int MIN_BLOCK_SIZE   = 2;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int BLK_W    = 5;
    localparam int OFF_W    = 6;
    localparam int COMPS_W  = 7;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic load_en;
        logic cmp_en;
        logic in_range;
        logic at_count;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// File: src/ibs_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibs_cell
// One slot of the sorted store: holds a value, shifts up on insert, and
// latches its ge and eq compare flags against a broadcast search key.
// ----------------------------------------------------------------------------
module ibs_cell (
    input  wire                                  i_clk,
    input  wire ibs_pkg::t_cell_ctrl             i_ctrl,
    input  wire logic signed [ibs_pkg::VALUE_W-1:0] i_key,
    input  wire logic signed [ibs_pkg::VALUE_W-1:0] i_prev_value,
    input  wire                                  i_prev_gt,
    output logic signed [ibs_pkg::VALUE_W-1:0]   o_value,
    output logic                                 o_gt,
    output logic                                 o_ge,
    output logic                                 o_eq
);

    logic signed [ibs_pkg::VALUE_W-1:0] r_value;
    logic signed [ibs_pkg::VALUE_W-1:0] n_value;
    logic                               r_ge;
    logic                               r_eq;

    assign o_gt = i_ctrl.in_range && (r_value > i_key);

    always_comb begin
        n_value = r_value;
        if (i_ctrl.load_en) begin
            if (i_prev_gt) begin
                n_value = i_prev_value;
            end else if (o_gt || i_ctrl.at_count) begin
                n_value = i_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_ctrl.cmp_en) begin
            r_ge <= (r_value >= i_key);
            r_eq <= (r_value == i_key);
        end
    end

    assign o_value = r_value;
    assign o_ge    = r_ge;
    assign o_eq    = r_eq;

endmodule
`default_nettype wire

// File: src/indexed_block_search_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_block_search_core
// Sorted value store built as a chain of cells with an indexed block search.
// Clear and load: result strobe in the cycle after start is taken; busy stays low.
// Search: all cells latch their compare flags on accept, then S_INDEX scans
// block maxima in order and S_BLOCK checks elements of the chosen block.
// Reset empties the store and sets block size to 5. Results cannot be stalled.
// ----------------------------------------------------------------------------
module indexed_block_search_core #(
    parameter int CAPACITY = ibs_pkg::CAPACITY
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     start,
    output logic                                    busy,
    input  wire logic [ibs_pkg::CMD_W-1:0]          i_cmd,
    input  wire logic signed [ibs_pkg::VALUE_W-1:0] i_value,
    input  wire                                     i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [ibs_pkg::BSIZE_W-1:0]        i_cfg_data,
    output logic                                    o_valid,
    output logic [ibs_pkg::STATUS_W-1:0]            o_status,
    output logic [ibs_pkg::BLK_W-1:0]               o_block_index,
    output logic [ibs_pkg::OFF_W-1:0]               o_offset_in_block,
    output logic [ibs_pkg::COMPS_W-1:0]             o_comparisons
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SW = ((CW > ibs_pkg::BSIZE_W) ? CW : ibs_pkg::BSIZE_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INDEX,
        S_BLOCK
    } t_state;

    t_state                           r_state, n_state;
    logic [CW-1:0]                    r_count, n_count;
    logic [ibs_pkg::BSIZE_W-1:0]      r_bsize;
    logic [CW-1:0]                    r_start, n_start;
    logic [CW-1:0]                    r_end, n_end;
    logic [CW-1:0]                    r_j, n_j;
    logic [CW-1:0]                    r_blk, n_blk;
    logic [CW:0]                      r_comps, n_comps;
    logic                             r_out_valid, n_out_valid;
    logic [ibs_pkg::STATUS_W-1:0]     r_out_status, n_out_status;
    logic [ibs_pkg::BLK_W-1:0]        r_out_blk, n_out_blk;
    logic [ibs_pkg::OFF_W-1:0]        r_out_off, n_out_off;
    logic [ibs_pkg::COMPS_W-1:0]      r_out_comps, n_out_comps;

    logic                             w_accept;
    logic                             w_full;
    logic [ibs_pkg::BSIZE_W-1:0]      w_bs_eff;
    logic [SW-1:0]                    w_sum;
    logic [CW-1:0]                    w_end;
    logic [CW-1:0]                    w_last;
    logic [CW-1:0]                    w_j_next;

    ibs_pkg::t_cell_ctrl              w_ctrl  [CAPACITY];
    logic signed [ibs_pkg::VALUE_W-1:0] w_value [CAPACITY];
    logic [CAPACITY-1:0]              w_gt;
    logic [CAPACITY-1:0]              w_ge;
    logic [CAPACITY-1:0]              w_eq;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_full      = (r_count == CW'(CAPACITY));

    assign w_bs_eff = (r_bsize < ibs_pkg::BSIZE_W'(ibs_pkg::MIN_BLOCK_SIZE))
                    ? ibs_pkg::BSIZE_W'(ibs_pkg::MIN_BLOCK_SIZE) : r_bsize;
    assign w_sum    = SW'(r_start) + SW'(w_bs_eff);
    assign w_end    = (w_sum < SW'(r_count)) ? CW'(w_sum) : r_count;
    assign w_last   = w_end - CW'(1);
    assign w_j_next = r_j + CW'(1);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            assign w_ctrl[gi].load_en  = w_accept && (i_cmd == ibs_pkg::CMD_LOAD) && !w_full;
            assign w_ctrl[gi].cmp_en   = w_accept && (i_cmd == ibs_pkg::CMD_SEARCH);
            assign w_ctrl[gi].in_range = (CW'(gi) < r_count);
            assign w_ctrl[gi].at_count = (CW'(gi) == r_count);

            if (gi == 0) begin : g_head
                ibs_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctrl       (w_ctrl[gi]),
                    .i_key        (i_value),
                    .i_prev_value ('0),
                    .i_prev_gt    (1'b0),
                    .o_value      (w_value[gi]),
                    .o_gt         (w_gt[gi]),
                    .o_ge         (w_ge[gi]),
                    .o_eq         (w_eq[gi])
                );
            end else begin : g_body
                ibs_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctrl       (w_ctrl[gi]),
                    .i_key        (i_value),
                    .i_prev_value (w_value[gi-1]),
                    .i_prev_gt    (w_gt[gi-1]),
                    .o_value      (w_value[gi]),
                    .o_gt         (w_gt[gi]),
                    .o_ge         (w_ge[gi]),
                    .o_eq         (w_eq[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_start      = r_start;
        n_end        = r_end;
        n_j          = r_j;
        n_blk        = r_blk;
        n_comps      = r_comps;
        n_out_valid  = 1'b0;
        n_out_status = r_out_status;
        n_out_blk    = r_out_blk;
        n_out_off    = r_out_off;
        n_out_comps  = r_out_comps;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_cmd)
                        ibs_pkg::CMD_CLEAR: begin
                            n_count      = '0;
                            n_out_valid  = 1'b1;
                            n_out_status = ibs_pkg::ST_ACCEPTED;
                            n_out_blk    = '0;
                            n_out_off    = '0;
                            n_out_comps  = '0;
                        end
                        ibs_pkg::CMD_LOAD: begin
                            n_out_valid  = 1'b1;
                            n_out_blk    = '0;
                            n_out_off    = '0;
                            n_out_comps  = '0;
                            if (w_full) begin
                                n_out_status = ibs_pkg::ST_FULL;
                            end else begin
                                n_count      = r_count + CW'(1);
                                n_out_status = ibs_pkg::ST_ACCEPTED;
                            end
                        end
                        ibs_pkg::CMD_SEARCH: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ibs_pkg::ST_EMPTY;
                                n_out_blk    = '0;
                                n_out_off    = '0;
                                n_out_comps  = '0;
                            end else begin
                                n_start = '0;
                                n_blk   = '0;
                                n_comps = '0;
                                n_state = S_INDEX;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INDEX: begin
                n_comps = r_comps + (CW+1)'(1);
                if (w_ge[w_last[IW-1:0]]) begin
                    n_end   = w_end;
                    n_j     = r_start;
                    n_state = S_BLOCK;
                end else if (w_end == r_count) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ibs_pkg::ST_MISS;
                    n_out_blk    = '0;
                    n_out_off    = '0;
                    n_out_comps  = ibs_pkg::COMPS_W'(n_comps);
                    n_state      = S_IDLE;
                end else begin
                    n_start = w_end;
                    n_blk   = r_blk + CW'(1);
                end
            end
            S_BLOCK: begin
                n_comps = r_comps + (CW+1)'(1);
                if (w_eq[r_j[IW-1:0]]) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ibs_pkg::ST_FOUND;
                    n_out_blk    = ibs_pkg::BLK_W'(r_blk);
                    n_out_off    = ibs_pkg::OFF_W'(r_j - r_start);
                    n_out_comps  = ibs_pkg::COMPS_W'(n_comps);
                    n_state      = S_IDLE;
                end else if (w_j_next == r_end) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ibs_pkg::ST_MISS;
                    n_out_blk    = ibs_pkg::BLK_W'(r_blk);
                    n_out_off    = '0;
                    n_out_comps  = ibs_pkg::COMPS_W'(n_comps);
                    n_state      = S_IDLE;
                end else begin
                    n_j = w_j_next;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_bsize     <= ibs_pkg::BSIZE_W'(ibs_pkg::BLOCK_SIZE_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bsize <= i_cfg_data;
            end
        end
        r_start      <= n_start;
        r_end        <= n_end;
        r_j          <= n_j;
        r_blk        <= n_blk;
        r_comps      <= n_comps;
        r_out_status <= n_out_status;
        r_out_blk    <= n_out_blk;
        r_out_off    <= n_out_off;
        r_out_comps  <= n_out_comps;
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_block_index     = r_out_blk;
    assign o_offset_in_block = r_out_off;
    assign o_comparisons     = r_out_comps;

endmodule
`default_nettype wire

// File: tb/indexed_block_search_core_tb.sv
// ----------------------------------------------------------------------------
// indexed_block_search_core_tb
// Drives clear, load and search commands into the sorted store with random
// gaps and block sizes from 0 to 127. It mirrors the sorted store to predict
// each status, block, offset and comparison count, then checks every result
// strobe in order.
// ----------------------------------------------------------------------------
module indexed_block_search_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 150;
    localparam int PHASE_ITEMS   = 87;

    localparam logic [ibs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [ibs_pkg::STATUS_W-1:0] status;
        logic [ibs_pkg::BLK_W-1:0]    block_index;
        logic [ibs_pkg::OFF_W-1:0]    offset_in_block;
        logic [ibs_pkg::COMPS_W-1:0]  comparisons;
    } t_search_result;

    class sorted_store_tracker;
        logic signed [ibs_pkg::VALUE_W-1:0] stored_values[ibs_pkg::CAPACITY];
        int unsigned                        value_count;
        logic [ibs_pkg::BSIZE_W-1:0]        block_size;
        t_search_result                     expected_results[$];
        int unsigned                        failures;

        function new();
            value_count = 0;
            block_size  = ibs_pkg::BLOCK_SIZE_RESET;
            failures    = 0;
        endfunction

        function void set_block_size(logic [ibs_pkg::BSIZE_W-1:0] size);
            block_size = size;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function logic signed [ibs_pkg::VALUE_W-1:0] pick_stored();
            return stored_values[$urandom_range(0, value_count - 1)];
        endfunction

        function void insert_sorted(logic signed [ibs_pkg::VALUE_W-1:0] value);
            int unsigned pos;
            pos = value_count;
            while (pos > 0 && stored_values[pos-1] > value) begin
                stored_values[pos] = stored_values[pos-1];
                pos--;
            end
            stored_values[pos] = value;
            value_count++;
        endfunction

        function t_search_result predict_search(logic signed [ibs_pkg::VALUE_W-1:0] target);
            t_search_result r;
            int unsigned    span;
            int unsigned    first;
            int unsigned    last;
            int unsigned    blk;
            int unsigned    comps;
            bit             hit;
            r = '0;
            if (value_count == 0) begin
                r.status = ibs_pkg::ST_EMPTY;
                return r;
            end
            span  = (block_size < ibs_pkg::MIN_BLOCK_SIZE) ? ibs_pkg::MIN_BLOCK_SIZE
                                                          : block_size;
            first = 0;
            last  = 0;
            blk   = 0;
            comps = 0;
            hit   = 1'b0;
            while (!hit && first < value_count) begin
                last = (value_count - first > span) ? first + span : value_count;
                comps++;
                if (target <= stored_values[last-1]) begin
                    hit = 1'b1;
                end else begin
                    blk++;
                    first += span;
                end
            end
            r.status = ibs_pkg::ST_MISS;
            if (hit) begin
                r.block_index = ibs_pkg::BLK_W'(blk);
                for (int unsigned j = first; j < last; j++) begin
                    comps++;
                    if (stored_values[j] == target) begin
                        r.status          = ibs_pkg::ST_FOUND;
                        r.offset_in_block = ibs_pkg::OFF_W'(j - first);
                        break;
                    end
                end
            end
            r.comparisons = ibs_pkg::COMPS_W'(comps);
            return r;
        endfunction

        function void note_command(logic [ibs_pkg::CMD_W-1:0] cmd,
                                   logic signed [ibs_pkg::VALUE_W-1:0] value);
            t_search_result r;
            r = '0;
            case (cmd)
                ibs_pkg::CMD_CLEAR: begin
                    value_count = 0;
                    expected_results.push_back(r);
                end
                ibs_pkg::CMD_LOAD: begin
                    if (value_count >= ibs_pkg::CAPACITY) begin
                        r.status = ibs_pkg::ST_FULL;
                    end else begin
                        insert_sorted(value);
                    end
                    expected_results.push_back(r);
                end
                ibs_pkg::CMD_SEARCH: begin
                    expected_results.push_back(predict_search(value));
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_search_result got);
            t_search_result want;
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction: status %0d", got.status);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                failures++;
            end
            if (got.block_index !== want.block_index) begin
                $error("block_index: expected %0d, got %0d", want.block_index, got.block_index);
                failures++;
            end
            if (got.offset_in_block !== want.offset_in_block) begin
                $error("offset_in_block: expected %0d, got %0d",
                       want.offset_in_block, got.offset_in_block);
                failures++;
            end
            if (got.comparisons !== want.comparisons) begin
                $error("comparisons: expected %0d, got %0d", want.comparisons, got.comparisons);
                failures++;
            end
        endfunction
    endclass

    logic                                i_clk       = 1'b0;
    logic                                i_rst_n     = 1'b0;
    logic                                start       = 1'b0;
    logic                                busy;
    logic [ibs_pkg::CMD_W-1:0]           i_cmd       = ibs_pkg::CMD_CLEAR;
    logic signed [ibs_pkg::VALUE_W-1:0]  i_value     = '0;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [ibs_pkg::BSIZE_W-1:0]         i_cfg_data  = '0;
    logic                                o_valid;
    logic [ibs_pkg::STATUS_W-1:0]        o_status;
    logic [ibs_pkg::BLK_W-1:0]           o_block_index;
    logic [ibs_pkg::OFF_W-1:0]           o_offset_in_block;
    logic [ibs_pkg::COMPS_W-1:0]         o_comparisons;

    sorted_store_tracker sb;

    indexed_block_search_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_value           (i_value),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_block_index     (o_block_index),
        .o_offset_in_block (o_offset_in_block),
        .o_comparisons     (o_comparisons)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result({o_status, o_block_index, o_offset_in_block, o_comparisons});
        end
    end

    function automatic logic signed [ibs_pkg::VALUE_W-1:0] random_value();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return 32'sh7FFF_FFFF;
        if (r == 1) return 32'sh8000_0000;
        if (r < 6) return $urandom();
        return int'($urandom_range(0, 63)) - 32;
    endfunction

    function automatic logic signed [ibs_pkg::VALUE_W-1:0] search_target();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (sb.value_count != 0 && r < 60) return sb.pick_stored();
        if (sb.value_count != 0 && r < 75) return sb.pick_stored() + ($urandom_range(0, 1) ? 1 : -1);
        return random_value();
    endfunction

    function automatic int unsigned gap_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic issue(input logic [ibs_pkg::CMD_W-1:0] cmd,
                         input logic signed [ibs_pkg::VALUE_W-1:0] value);
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(cmd, value);
    endtask

    task automatic pause(input int unsigned cycles);
        if (cycles == 0) return;
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_block_size(input logic [ibs_pkg::BSIZE_W-1:0] size);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_block_size(size);
    endtask

    task automatic run_phase(input int unsigned n_items, input int unsigned load_pct,
                             input bit idle_on);
        int unsigned done;
        int unsigned roll;
        done = 0;
        while (done < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                issue(CMD_UNUSED, random_value());
            end else begin
                if (roll < 4) begin
                    issue(ibs_pkg::CMD_CLEAR, random_value());
                end else if (roll < 4 + load_pct) begin
                    issue(ibs_pkg::CMD_LOAD, random_value());
                end else begin
                    issue(ibs_pkg::CMD_SEARCH, search_target());
                end
                done++;
            end
            if ($urandom_range(0, 99) < 2) begin
                drain();
            end else if (idle_on) begin
                pause(gap_cycles());
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(ibs_pkg::CMD_SEARCH, 0);
        issue(ibs_pkg::CMD_LOAD, 32'sh7FFF_FFFF);
        issue(ibs_pkg::CMD_LOAD, 32'sh8000_0000);
        issue(ibs_pkg::CMD_LOAD, 0);
        issue(ibs_pkg::CMD_LOAD, 0);
        issue(ibs_pkg::CMD_LOAD, -1);
        issue(ibs_pkg::CMD_SEARCH, 32'sh8000_0000);
        issue(ibs_pkg::CMD_SEARCH, 32'sh7FFF_FFFF);
        issue(ibs_pkg::CMD_SEARCH, 0);
        issue(ibs_pkg::CMD_SEARCH, 7);
        issue(CMD_UNUSED, 5);
        issue(ibs_pkg::CMD_CLEAR, 0);
        issue(ibs_pkg::CMD_LOAD, 10);
        issue(ibs_pkg::CMD_LOAD, 20);
        issue(ibs_pkg::CMD_LOAD, 30);
        issue(ibs_pkg::CMD_SEARCH, 40);
        issue(ibs_pkg::CMD_SEARCH, 20);
        issue(ibs_pkg::CMD_SEARCH, -5);
        issue(ibs_pkg::CMD_LOAD, 32'sh8000_0000);
        issue(ibs_pkg::CMD_SEARCH, 32'sh8000_0000);

        write_block_size(2);
        run_phase(PHASE_ITEMS, 60, 1'b1);
        write_block_size(64);
        run_phase(PHASE_ITEMS, 80, 1'b1);
        write_block_size(0);
        run_phase(PHASE_ITEMS, 40, 1'b0);
        write_block_size(127);
        run_phase(PHASE_ITEMS, 50, 1'b1);
        write_block_size(1);
        run_phase(PHASE_ITEMS, 90, 1'b1);
        write_block_size(7);
        run_phase(PHASE_ITEMS, 30, 1'b1);
        write_block_size(5);
        run_phase(PHASE_ITEMS, 60, 1'b0);
        write_block_size(ibs_pkg::BSIZE_W'($urandom_range(2, 64)));
        run_phase(PHASE_ITEMS, 50, 1'b1);
        write_block_size(ibs_pkg::BSIZE_W'($urandom_range(0, 127)));
        run_phase(PHASE_ITEMS, 45, 1'b1);

        drain();
        repeat (END_CYCLES) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
